// ----- hdl/aesofb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the AES S-box for the AES-128 OFB stream cipher.
// No dependencies.
package aesofb_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_HIGH = 2'd0,
		REG_KEY_LOW  = 2'd1,
		REG_IV_HIGH  = 2'd2,
		REG_IV_LOW   = 2'd3
	} cfg_reg_t;

	localparam int BLK_W      = 128;
	localparam int NUM_ROUNDS = 10;
	localparam logic [7:0] RCON_INIT = 8'h01;

	// control to the cipher core
	typedef struct packed {
		logic start;
	} core_ctrl_t;

	// status from the cipher core
	typedef struct packed {
		logic done;
	} core_stat_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_SUB,
		CS_MIX
	} core_state_t;

	typedef enum logic [1:0] {
		TS_IDLE,
		TS_ENC,
		TS_EMIT
	} top_state_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// multiply by x in GF(2^8)
	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

// ----- hdl/aes128_ofb_stream_cipher_top.sv -----
`timescale 1ns / 1ps
// AES-128 OFB byte-stream cipher, top level.
// Depends on aesofb_pkg and aesofb_core.
//
// Usage:
//   Configuration: write key_high/key_low/iv_high/iv_low through cfg_valid,
//   cfg_index, cfg_data (cfg_ready is always high). New values take effect
//   at the next message start. Write only while the block is idle.
//   Input: a transfer of data_byte/first when in_valid is high and in_stall
//   low. first restarts the keystream from the IV; the first byte after reset
//   always starts a message.
//   Output: one out_byte per input byte, a transfer when out_valid is high and
//   out_stall low. out_byte is data_byte XOR the next keystream byte.
// Sequencing:
//   A byte within a keystream block goes from its transfer to the EMIT state
//   and into the output register once that is free; the input is taken again
//   after that. On a message start or every 16th byte, the byte-serial AES core
//   runs first (state ENC): 10 rounds, each a substitution pass over the 16
//   bytes and then a column pass, before the byte reaches the output register.
//   The core's single S-box lane for state bytes sets this pace.
//   A stalled receiver holds the result; the next byte then waits in EMIT.
// Reset: clears control state; the next byte starts a message.
module aes128_ofb_stream_cipher_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [aesofb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [63:0]                        cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         data_byte,
	input  logic                               first,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [7:0]                         out_byte
);

	logic [63:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
	logic [aesofb_pkg::BLK_W-1:0] msg_key_q;
	logic [7:0] data_q;
	logic [3:0] pos_q;
	logic       ready_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;

	aesofb_pkg::top_state_t state_q, state_d;
	aesofb_pkg::core_ctrl_t core_ctrl;
	aesofb_pkg::core_stat_t core_stat;
	logic [aesofb_pkg::BLK_W-1:0] core_key, core_blk, ks_blk;

	logic in_xfer, is_start, out_load;
	logic [3:0] ks_idx;
	logic [7:0] ks_byte;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != aesofb_pkg::TS_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign is_start  = first || !ready_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			iv_high_q  <= '0;
			iv_low_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (aesofb_pkg::cfg_reg_t'(cfg_index))
				aesofb_pkg::REG_KEY_HIGH: key_high_q <= cfg_data;
				aesofb_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data;
				aesofb_pkg::REG_IV_HIGH:  iv_high_q  <= cfg_data;
				aesofb_pkg::REG_IV_LOW:   iv_low_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// core launch: fresh key and IV on a start, else chain the last block at a block boundary
	always_comb begin
		core_ctrl.start = 1'b0;
		core_key        = msg_key_q;
		core_blk        = ks_blk;
		if (in_xfer) begin
			if (is_start) begin
				core_ctrl.start = 1'b1;
				core_key        = {key_high_q, key_low_q};
				core_blk        = {iv_high_q, iv_low_q};
			end else if (pos_q == 4'd0) begin
				core_ctrl.start = 1'b1;
			end
		end
	end

	aesofb_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (core_ctrl),
		.key_in  (core_key),
		.blk_in  (core_blk),
		.stat    (core_stat),
		.blk_out (ks_blk)
	);

	// current keystream byte, byte 0 in the top bits
	assign ks_idx  = ~pos_q;
	assign ks_byte = ks_blk[{ks_idx, 3'b000} +: 8];

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aesofb_pkg::TS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		case (state_q)
			aesofb_pkg::TS_IDLE: begin
				if (in_xfer) begin
					state_d = core_ctrl.start ? aesofb_pkg::TS_ENC : aesofb_pkg::TS_EMIT;
				end
			end
			aesofb_pkg::TS_ENC: begin
				if (core_stat.done) state_d = aesofb_pkg::TS_EMIT;
			end
			aesofb_pkg::TS_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = aesofb_pkg::TS_IDLE;
				end
			end
			default: state_d = aesofb_pkg::TS_IDLE;
		endcase
	end

	// position, message state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			ready_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer && is_start) begin
				pos_q   <= '0;
				ready_q <= 1'b1;
			end else if (out_load) begin
				pos_q <= pos_q + 4'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			data_q <= data_byte;
			if (is_start) msg_key_q <= {key_high_q, key_low_q};
		end
		if (out_load) out_byte_q <= data_q ^ ks_byte;
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

endmodule

// ----- hdl/aesofb_core.sv -----
`timescale 1ns / 1ps
// Byte-serial AES-128 encryption core with on-the-fly key expansion.
// Depends on aesofb_pkg.
module aesofb_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  aesofb_pkg::core_ctrl_t        ctrl,
	input  logic [aesofb_pkg::BLK_W-1:0]  key_in,
	input  logic [aesofb_pkg::BLK_W-1:0]  blk_in,
	output aesofb_pkg::core_stat_t        stat,
	output logic [aesofb_pkg::BLK_W-1:0]  blk_out
);

	aesofb_pkg::core_state_t state_q, state_d;

	logic [7:0]  st_q  [16];
	logic [7:0]  tmp_q [16];
	logic [31:0] rk_q  [4];
	logic [7:0]  rcon_q;
	logic [3:0]  rnd_q;
	logic [3:0]  cnt_q;

	// ShiftRows source index for the byte being substituted
	logic [1:0] sub_c, sub_r, src_c;
	logic [3:0] src_idx;
	assign sub_c   = cnt_q[3:2];
	assign sub_r   = cnt_q[1:0];
	assign src_c   = sub_c + sub_r;
	assign src_idx = {src_c, sub_r};

	// column datapath: MixColumns and next round-key word
	logic [1:0]  col;
	logic [1:0]  col_prev;
	logic        last_rnd;
	logic [7:0]  a0, a1, a2, a3, tt;
	logic [7:0]  m0, m1, m2, m3;
	logic [31:0] rot_w, sub_w, new_w;
	assign col      = cnt_q[1:0];
	assign col_prev = col - 2'd1;
	assign last_rnd = (rnd_q == 4'(aesofb_pkg::NUM_ROUNDS));

	always_comb begin
		a0 = tmp_q[{col, 2'd0}];
		a1 = tmp_q[{col, 2'd1}];
		a2 = tmp_q[{col, 2'd2}];
		a3 = tmp_q[{col, 2'd3}];
		tt = a0 ^ a1 ^ a2 ^ a3;
		if (last_rnd) begin
			m0 = a0; m1 = a1; m2 = a2; m3 = a3;
		end else begin
			m0 = a0 ^ tt ^ aesofb_pkg::xtime(a0 ^ a1);
			m1 = a1 ^ tt ^ aesofb_pkg::xtime(a1 ^ a2);
			m2 = a2 ^ tt ^ aesofb_pkg::xtime(a2 ^ a3);
			m3 = a3 ^ tt ^ aesofb_pkg::xtime(a3 ^ a0);
		end
		rot_w = {rk_q[3][23:0], rk_q[3][31:24]};
		sub_w = {aesofb_pkg::SBOX[rot_w[31:24]], aesofb_pkg::SBOX[rot_w[23:16]],
			aesofb_pkg::SBOX[rot_w[15:8]], aesofb_pkg::SBOX[rot_w[7:0]]};
		if (col == 2'd0) begin
			new_w = rk_q[0] ^ sub_w ^ {rcon_q, 24'd0};
		end else begin
			new_w = rk_q[col] ^ rk_q[col_prev];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aesofb_pkg::CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		stat.done = 1'b0;
		case (state_q)
			aesofb_pkg::CS_IDLE: begin
				if (ctrl.start) state_d = aesofb_pkg::CS_SUB;
			end
			aesofb_pkg::CS_SUB: begin
				if (cnt_q == 4'd15) state_d = aesofb_pkg::CS_MIX;
			end
			aesofb_pkg::CS_MIX: begin
				if (col == 2'd3) begin
					if (last_rnd) begin
						state_d   = aesofb_pkg::CS_IDLE;
						stat.done = 1'b1;
					end else begin
						state_d = aesofb_pkg::CS_SUB;
					end
				end
			end
			default: state_d = aesofb_pkg::CS_IDLE;
		endcase
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			rnd_q  <= 4'd1;
			rcon_q <= aesofb_pkg::RCON_INIT;
		end else begin
			case (state_q)
				aesofb_pkg::CS_IDLE: begin
					cnt_q  <= '0;
					rnd_q  <= 4'd1;
					rcon_q <= aesofb_pkg::RCON_INIT;
				end
				aesofb_pkg::CS_SUB: begin
					cnt_q <= cnt_q + 4'd1;
				end
				aesofb_pkg::CS_MIX: begin
					if (col == 2'd3) begin
						cnt_q  <= '0;
						rnd_q  <= rnd_q + 4'd1;
						rcon_q <= aesofb_pkg::xtime(rcon_q);
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	// state, scratch and round-key datapath
	always_ff @(posedge clk) begin
		case (state_q)
			aesofb_pkg::CS_IDLE: begin
				if (ctrl.start) begin
					for (int k = 0; k < 16; k++) begin
						st_q[k] <= blk_in[127 - 8*k -: 8] ^ key_in[127 - 8*k -: 8];
					end
					for (int w = 0; w < 4; w++) begin
						rk_q[w] <= key_in[127 - 32*w -: 32];
					end
				end
			end
			aesofb_pkg::CS_SUB: begin
				tmp_q[cnt_q] <= aesofb_pkg::SBOX[st_q[src_idx]];
			end
			aesofb_pkg::CS_MIX: begin
				rk_q[col]            <= new_w;
				st_q[{col, 2'd0}] <= m0 ^ new_w[31:24];
				st_q[{col, 2'd1}] <= m1 ^ new_w[23:16];
				st_q[{col, 2'd2}] <= m2 ^ new_w[15:8];
				st_q[{col, 2'd3}] <= m3 ^ new_w[7:0];
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int k = 0; k < 16; k++) begin
			blk_out[127 - 8*k -: 8] = st_q[k];
		end
	end

endmodule

// ----- hdl/aesofb_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the AES-128 OFB stream cipher, bound to the top level.
// Depends on aes128_ofb_stream_cipher_top ports only.
module aesofb_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_ready,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [7:0] out_byte
);

	// one byte in flight: a transfer blocks the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// a new result appears only while the input side was busy with it
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a pending byte");

	// stalled result is held
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte))
		else $error("stalled result dropped or changed");

	// configuration port never back-pressures
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("cfg_ready low");

endmodule

bind aes128_ofb_stream_cipher_top aesofb_checker u_aesofb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_ready (cfg_ready),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte)
);

// ----- tb/sv/aesofb_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the AES-128 OFB stream cipher: tracks register writes, predicts
// each output byte from accepted input bytes and compares. Depends on aesofb_pkg.
module aesofb_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [aesofb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  out_byte,
	output int          errors,
	output int          pending
);

	logic [63:0] cfg_reg [4];
	logic [31:0] rkey [44];
	logic [7:0]  ks [16];
	logic [7:0]  tmp [16];
	logic [3:0]  ks_pos;
	logic        started;
	logic [7:0]  expected_bytes [$];

	function automatic logic [7:0] gf_dbl(input logic [7:0] a);
		gf_dbl = (a << 1) ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// key schedule from the current key registers
	task expand_key();
		logic [127:0] key;
		logic [31:0]  t;
		logic [7:0]   rc;
		key = {cfg_reg[aesofb_pkg::REG_KEY_HIGH], cfg_reg[aesofb_pkg::REG_KEY_LOW]};
		rc = 8'h01;
		for (int i = 0; i < 4; i++)
			rkey[i] = key[127-32*i -: 32];
		for (int i = 4; i < 44; i++) begin
			t = rkey[i-1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {aesofb_pkg::SBOX[t[31:24]], aesofb_pkg::SBOX[t[23:16]],
					aesofb_pkg::SBOX[t[15:8]], aesofb_pkg::SBOX[t[7:0]]};
				t ^= {rc, 24'h0};
				rc = gf_dbl(rc);
			end
			rkey[i] = rkey[i-4] ^ t;
		end
	endtask

	task mix_in_rkey(input int rnd);
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				ks[c*4+r] ^= rkey[rnd*4+c][31-8*r -: 8];
	endtask

	// encrypt the keystream block in place
	task encrypt_ks();
		logic [7:0] a0, a1, a2, a3, t;
		mix_in_rkey(0);
		for (int rnd = 1; rnd <= 10; rnd++) begin
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					tmp[c*4+r] = aesofb_pkg::SBOX[ks[((c+r)%4)*4+r]];
			if (rnd != 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = tmp[c*4]; a1 = tmp[c*4+1]; a2 = tmp[c*4+2]; a3 = tmp[c*4+3];
					t = a0 ^ a1 ^ a2 ^ a3;
					tmp[c*4]   = a0 ^ t ^ gf_dbl(a0 ^ a1);
					tmp[c*4+1] = a1 ^ t ^ gf_dbl(a1 ^ a2);
					tmp[c*4+2] = a2 ^ t ^ gf_dbl(a2 ^ a3);
					tmp[c*4+3] = a3 ^ t ^ gf_dbl(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++)
				ks[i] = tmp[i];
			mix_in_rkey(rnd);
		end
	endtask

	// next cipher byte for one accepted input byte
	task cipher_byte(input logic [7:0] d, input logic f, output logic [7:0] res);
		logic [127:0] iv;
		iv = {cfg_reg[aesofb_pkg::REG_IV_HIGH], cfg_reg[aesofb_pkg::REG_IV_LOW]};
		if (f || !started) begin
			expand_key();
			for (int i = 0; i < 16; i++)
				ks[i] = iv[127-8*i -: 8];
			encrypt_ks();
			ks_pos = '0;
			started = 1'b1;
		end else if (ks_pos == 0) begin
			encrypt_ks();
		end
		res = d ^ ks[ks_pos];
		ks_pos = ks_pos + 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [7:0] want;
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				cfg_reg[i] = '0;
			ks_pos = '0;
			started = 1'b0;
			expected_bytes.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				cfg_reg[cfg_index] = cfg_data;
			// output transfer belongs to an earlier input, so compare first
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected out_byte %02h", out_byte);
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want) begin
						errors++;
						if (errors <= 10)
							$display("out_byte mismatch: expected %02h actual %02h",
								want, out_byte);
					end
				end
			end
			if (in_valid && !in_stall) begin
				cipher_byte(data_byte, first, want);
				expected_bytes = {expected_bytes, want};
			end
			pending = expected_bytes.size();
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the AES-128 OFB stream cipher: clock, reset, stimulus and verdict.
// Depends on aesofb_pkg, aes128_ofb_stream_cipher_top and aesofb_scoreboard.
module tb_top;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int BLOCK_LAT   = 250;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [aesofb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        first;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	int          errors;
	int          pending;
	int          cycles;
	int          burst_left;

	aes128_ofb_stream_cipher_top dut (.*);

	aesofb_scoreboard u_checker (.*);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: a random stall pattern per segment, one long hold-off
	initial begin
		int mode;
		out_stall = 1'b0;
		@(posedge arst_n);
		for (int seg = 0; ; seg++) begin
			if (seg == 60) begin
				out_stall <= 1'b1;
				repeat (800) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			for (int i = 0; i < 64; i++) begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 9) < 3);
					2: out_stall <= i[2];
					default: out_stall <= ($urandom_range(0, 9) < 8);
				endcase
				@(posedge clk);
			end
		end
	end

	// one input transfer; gaps fall between bursts of random length
	task send_byte(input logic [7:0] d, input logic f);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		first <= f;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
	endtask

	task write_reg(input aesofb_pkg::cfg_reg_t idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (BLOCK_LAT) @(posedge clk);
	endtask

	task load_settings(input logic [127:0] key, input logic [127:0] iv);
		write_reg(aesofb_pkg::REG_KEY_HIGH, key[127:64]);
		write_reg(aesofb_pkg::REG_KEY_LOW, key[63:0]);
		write_reg(aesofb_pkg::REG_IV_HIGH, iv[127:64]);
		write_reg(aesofb_pkg::REG_IV_LOW, iv[63:0]);
		cfg_valid <= 1'b0;
	endtask

	// messages with random content, a few with stray restarts inside
	task random_messages(input int n_items);
		int len;
		int sent;
		logic f;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
			for (int i = 0; i < len; i++) begin
				f = (i == 0) ? 1'b1 : ($urandom_range(0, 31) == 0);
				send_byte(8'($urandom_range(0, 255)), f);
			end
			sent += len;
		end
	endtask

	initial begin
		logic [127:0] key;
		logic [127:0] iv;
		arst_n = 1'b0;
		cycles = 0;
		burst_left = 0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		data_byte = '0;
		first = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, byte before any start, block crossing, restarts
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		for (int i = 0; i < 16; i++)
			send_byte(8'(i * 17), 1'b0);
		send_byte(8'ha5, 1'b1);
		send_byte(8'h5a, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'h00, 1'b1);
		send_byte(8'h80, 1'b0);

		for (int ph = 0; ph < 5; ph++) begin
			wait_drained();
			case (ph)
				0: begin
					key = '1;
					iv = '1;
				end
				1: begin
					key = 128'h000102030405060708090a0b0c0d0e0f;
					iv = 128'h00112233445566778899aabbccddeeff;
				end
				default: begin
					key = {$urandom, $urandom, $urandom, $urandom};
					iv = {$urandom, $urandom, $urandom, $urandom};
				end
			endcase
			load_settings(key, iv);
			random_messages(190);
		end

		// back to reset-like all-zero settings
		wait_drained();
		load_settings('0, '0);
		send_byte(8'h3c, 1'b1);
		send_byte(8'hc3, 1'b0);

		wait_drained();
		if (errors == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
